// ----- hw/rtl/bsrf_pkg.sv -----
// Package for the beeper sample resampler filter: widths, filter constants,
// parameter defaults and the sequencer's ALU operation type. No dependencies.

package bsrf_pkg;

    // Port field widths
    localparam int TICK_W   = 32;
    localparam int DAC_W    = 8;
    localparam int PERIOD_W = 24;
    localparam int SAMPLE_W = 16;

    // Parameter defaults
    localparam int MAX_BURST_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 8;

    // Sample period after reset, ticks per sample in Q16.8
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd69659;
    // Fraction bits of the period as written
    localparam int PERIOD_FRAC = 8;

    // Mix: speaker weight and DAC byte position
    localparam int                  MIX_W     = 16;
    localparam logic [MIX_W-1:0]    SPK_MIX   = 16'h7fff;
    localparam int                  DAC_SHIFT = 4;

    // Filter state, Q.8 sample units
    localparam int POLE_W      = 26;
    localparam int POLE_FRAC   = 8;
    localparam int DQ_W        = MIX_W + POLE_FRAC;
    // Difference terms stay within 28 signed bits
    localparam int DIFF_W      = 28;

    // Smoother coefficient 1/4 as a shift
    localparam int SMOOTH_SHIFT = 2;

    // Output pole coefficient 0.4 in Q0.16
    localparam int               COEF_W     = 15;
    localparam logic [COEF_W-1:0] COEF_OUT  = 15'd26214;
    localparam int               COEF_SHIFT = 16;
    localparam int               PROD_W     = DIFF_W + COEF_W + 1;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

// ----- hw/rtl/bsrf_if.sv -----
// Handshake channels of the beeper sample resampler filter: input word
// and result word. Depends on bsrf_pkg for the field widths.

interface bsrf_in_if;
    logic                         valid;
    logic                         ready;
    logic [bsrf_pkg::TICK_W-1:0]  tick_count;
    logic                         speaker_level;
    logic [bsrf_pkg::DAC_W-1:0]   dac_byte;

    modport source (output valid, output tick_count, output speaker_level,
                    output dac_byte, input ready);
    modport sink   (input valid, input tick_count, input speaker_level,
                    input dac_byte, output ready);
endinterface

interface bsrf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bsrf_pkg::SAMPLE_W-1:0] sample;
    logic                                last_of_run;

    modport source (output valid, output sample, output last_of_run, input ready);
    modport sink   (input valid, input sample, input last_of_run, output ready);
endinterface

// ----- hw/rtl/bsrf_alu.sv -----
// Shared add/subtract unit of the beeper sample resampler filter.
// Depends on bsrf_pkg for the operation type.

module bsrf_alu #(
    parameter int ALU_W = 40
) (
    input  logic signed [ALU_W-1:0] a,
    input  logic signed [ALU_W-1:0] b,
    input  bsrf_pkg::alu_op_t       op,
    output logic signed [ALU_W-1:0] sum
);

    logic [ALU_W-1:0] b_eff;
    logic             carry_in;

    // Invert and add one for subtraction
    always_comb
    begin
        carry_in = (op == bsrf_pkg::ALU_SUB);
        b_eff    = carry_in ? ~b : b;
        sum      = a + $signed(b_eff) + $signed({{(ALU_W-1){1'b0}}, carry_in});
    end

endmodule

// ----- hw/rtl/beeper_sample_resampler_filter_core.sv -----
// Top level of the beeper sample resampler filter: sequencer, filter state
// and output register. Depends on bsrf_pkg, bsrf_if and bsrf_alu.

// Each input word brings the tick counter and the present speaker and DAC
// levels. The block emits one filtered 16-bit sample for every output
// sample period that the tick counter has passed, up to MAX_BURST samples
// per word; remaining lag is worked off by later words. All arithmetic runs
// through one shared adder under a sequencer, plus one registered constant
// multiply: a word passes the idle state and a due check, and each sample
// adds seven filter/time steps and a further due check, and the result side
// may hold off a finished word. The input side is ready only while the
// sequencer is idle. The last sample of a word carries last_of_run. The user
// is to write sample_period through cfg_write and cfg_data only while the block is
// idle, which the block itself does not enforce; it then takes effect on the next word.

module beeper_sample_resampler_filter_core #(
    parameter int MAX_BURST     = bsrf_pkg::MAX_BURST_DEF,
    parameter int FRACTION_BITS = bsrf_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bsrf_pkg::PERIOD_W-1:0]  cfg_data,
    bsrf_in_if.sink                        item,
    bsrf_out_if.source                     result
);

    localparam int TIME_W = bsrf_pkg::TICK_W + FRACTION_BITS;
    localparam int ALU_W  = (TIME_W > bsrf_pkg::DIFF_W) ? TIME_W : bsrf_pkg::DIFF_W;
    localparam int PW     = bsrf_pkg::PERIOD_W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(MAX_BURST + 1);
    localparam int QW     = bsrf_pkg::POLE_W - bsrf_pkg::POLE_FRAC;
    localparam logic signed [ALU_W-1:0] POLE_HI = ALU_W'(2**(bsrf_pkg::POLE_W-1) - 1);
    localparam logic signed [ALU_W-1:0] POLE_LO = -POLE_HI - ALU_W'(1);
    localparam logic signed [QW-1:0]    Q_HI    = QW'(2**(bsrf_pkg::SAMPLE_W-1) - 1);
    localparam logic signed [QW-1:0]    Q_LO    = -Q_HI - QW'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SM_DIFF,
        S_SM_ACC,
        S_OP_DIFF1,
        S_OP_DIFF2,
        S_OP_MUL,
        S_OP_ACC,
        S_ADVANCE
    } state_t;

    // Control and filter state
    state_t                                state_reg;
    logic [CNT_W-1:0]                      cnt_reg;
    logic                                  pend_reg;
    logic                                  out_valid_reg;
    logic [bsrf_pkg::PERIOD_W-1:0]         period_reg;
    logic [TIME_W-1:0]                     ntime_reg;
    logic signed [bsrf_pkg::POLE_W-1:0]    smooth_reg;
    logic signed [bsrf_pkg::POLE_W-1:0]    opole_reg;

    // Payload
    logic [bsrf_pkg::TICK_W-1:0]           ticks_reg;
    logic signed [bsrf_pkg::DQ_W-1:0]      dq_reg;
    logic signed [ALU_W-1:0]               tmp_reg;
    logic signed [bsrf_pkg::PROD_W-1:0]    prod_reg;
    logic signed [bsrf_pkg::SAMPLE_W-1:0]  pend_sample_reg;
    logic signed [bsrf_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic                                  out_last_reg;

    // Datapath signals
    logic signed [ALU_W-1:0]               alu_a;
    logic signed [ALU_W-1:0]               alu_b;
    bsrf_pkg::alu_op_t                     alu_op;
    logic signed [ALU_W-1:0]               alu_sum;
    logic signed [ALU_W-1:0]               pole_clamped;
    logic [TIME_W-1:0]                     now;
    logic [TIME_W-1:0]                     diff;
    logic [PW-1:0]                         period_wide;
    logic [TIME_W-1:0]                     step;
    logic                                  due;
    logic                                  go;
    logic                                  out_free;
    logic                                  load_out;
    logic [bsrf_pkg::MIX_W-1:0]            mix;
    logic signed [bsrf_pkg::POLE_W-1:0]    q_bias;
    logic signed [QW-1:0]                  q_full;
    logic signed [bsrf_pkg::SAMPLE_W-1:0]  q_sat;
    logic signed [bsrf_pkg::PROD_W-bsrf_pkg::COEF_SHIFT-1:0] prod_shifted;
    logic signed [bsrf_pkg::DIFF_W-1:0]    tmp_narrow;

    // Mix the speaker and DAC, wrapping to 16 bits
    assign mix = (item.speaker_level ? bsrf_pkg::SPK_MIX : '0)
               + {{(bsrf_pkg::MIX_W - bsrf_pkg::DAC_W - bsrf_pkg::DAC_SHIFT){1'b0}},
                  item.dac_byte, {bsrf_pkg::DAC_SHIFT{1'b0}}};

    // Rescale the period to the time fraction format
    assign period_wide = {period_reg, {FRACTION_BITS{1'b0}}};
    assign step        = TIME_W'(period_wide[PW-1:bsrf_pkg::PERIOD_FRAC]);
    assign now         = {ticks_reg, {FRACTION_BITS{1'b0}}};

    // Select shared adder operands per step
    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = bsrf_pkg::ALU_ADD;
        case (state_reg)
            S_CHECK:
            begin
                alu_a  = ALU_W'(now);
                alu_b  = ALU_W'(ntime_reg);
                alu_op = bsrf_pkg::ALU_SUB;
            end
            S_SM_DIFF, S_OP_DIFF1:
            begin
                alu_a  = ALU_W'(dq_reg);
                alu_b  = ALU_W'(smooth_reg);
                alu_op = bsrf_pkg::ALU_SUB;
            end
            S_SM_ACC:
            begin
                alu_a  = ALU_W'(smooth_reg);
                alu_b  = tmp_reg >>> bsrf_pkg::SMOOTH_SHIFT;
            end
            S_OP_DIFF2:
            begin
                alu_a  = tmp_reg;
                alu_b  = ALU_W'(opole_reg);
                alu_op = bsrf_pkg::ALU_SUB;
            end
            S_OP_ACC:
            begin
                alu_a  = ALU_W'(opole_reg);
                alu_b  = ALU_W'(prod_shifted);
            end
            S_ADVANCE:
            begin
                alu_a  = ALU_W'(ntime_reg);
                alu_b  = ALU_W'(step);
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
            end
        endcase
    end

    bsrf_alu #(
        .ALU_W (ALU_W)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .op  (alu_op),
        .sum (alu_sum)
    );

    // Due test on the wrapped time difference, and pole saturation
    always_comb
    begin
        diff         = alu_sum[TIME_W-1:0];
        due          = (|diff) && !diff[TIME_W-1];
        go           = due && (cnt_reg < CNT_W'(MAX_BURST));
        out_free     = !out_valid_reg || result.ready;
        load_out     = (state_reg == S_CHECK) && pend_reg && out_free;
        prod_shifted = prod_reg[bsrf_pkg::PROD_W-1:bsrf_pkg::COEF_SHIFT];
        tmp_narrow   = tmp_reg[bsrf_pkg::DIFF_W-1:0];
        if (alu_sum > POLE_HI)
            pole_clamped = POLE_HI;
        else if (alu_sum < POLE_LO)
            pole_clamped = POLE_LO;
        else
            pole_clamped = alu_sum;
    end

    // Truncate the output pole toward zero and saturate to 16 bits
    always_comb
    begin
        q_bias = opole_reg + (opole_reg[bsrf_pkg::POLE_W-1]
                 ? bsrf_pkg::POLE_W'((2**bsrf_pkg::POLE_FRAC) - 1) : '0);
        q_full = QW'(q_bias >>> bsrf_pkg::POLE_FRAC);
        if (q_full > Q_HI)
            q_sat = Q_HI[bsrf_pkg::SAMPLE_W-1:0];
        else if (q_full < Q_LO)
            q_sat = Q_LO[bsrf_pkg::SAMPLE_W-1:0];
        else
            q_sat = q_full[bsrf_pkg::SAMPLE_W-1:0];
    end

    // Sequencer, filter state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= bsrf_pkg::PERIOD_RESET;
            ntime_reg     <= '0;
            smooth_reg    <= '0;
            opole_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
                period_reg <= cfg_data;

            // Drop the result word once taken, unless a new one loads
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // Hold while a finished sample waits for the output slot
                    if (!pend_reg || out_free)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= go ? S_SM_DIFF : S_IDLE;
                    end
                end
                S_SM_DIFF:  state_reg <= S_SM_ACC;
                S_SM_ACC:
                begin
                    smooth_reg <= pole_clamped[bsrf_pkg::POLE_W-1:0];
                    state_reg  <= S_OP_DIFF1;
                end
                S_OP_DIFF1: state_reg <= S_OP_DIFF2;
                S_OP_DIFF2: state_reg <= S_OP_MUL;
                S_OP_MUL:   state_reg <= S_OP_ACC;
                S_OP_ACC:
                begin
                    opole_reg <= pole_clamped[bsrf_pkg::POLE_W-1:0];
                    state_reg <= S_ADVANCE;
                end
                S_ADVANCE:
                begin
                    ntime_reg <= alu_sum[TIME_W-1:0];
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    pend_reg  <= 1'b1;
                    state_reg <= S_CHECK;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item.valid)
        begin
            ticks_reg <= item.tick_count;
            dq_reg    <= $signed({mix, {bsrf_pkg::POLE_FRAC{1'b0}}});
        end
        if (state_reg == S_SM_DIFF || state_reg == S_OP_DIFF1 || state_reg == S_OP_DIFF2)
            tmp_reg <= alu_sum;
        if (state_reg == S_OP_MUL)
            prod_reg <= bsrf_pkg::PROD_W'(tmp_narrow)
                      * $signed({1'b0, bsrf_pkg::COEF_OUT});
        if (state_reg == S_ADVANCE)
            pend_sample_reg <= q_sat;
        if (load_out)
        begin
            out_sample_reg <= pend_sample_reg;
            out_last_reg   <= !go;
        end
    end

    assign item.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.sample      = out_sample_reg;
    assign result.last_of_run = out_last_reg;

endmodule

// ----- sim/bsrf_sample_checker.sv -----
`timescale 1ns / 1ps
// Sample checker for the beeper sample resampler filter: watches the period
// port and both channels, predicts every sample and compares the results.
// Depends on bsrf_pkg and the channel interfaces in bsrf_if.

module bsrf_sample_checker #(
    parameter int MAX_BURST     = bsrf_pkg::MAX_BURST_DEF,
    parameter int FRACTION_BITS = bsrf_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bsrf_pkg::PERIOD_W-1:0] cfg_data,
    bsrf_in_if                            item,
    bsrf_out_if                           result,
    output int                            fail_count,
    output int                            outstanding
);

    localparam int     TIME_W  = bsrf_pkg::TICK_W + FRACTION_BITS;
    localparam longint POLE_HI = 64'sd33554431;
    localparam longint POLE_LO = -64'sd33554432;

    typedef struct packed {
        logic signed [bsrf_pkg::SAMPLE_W-1:0] sample;
        logic                                 last_of_run;
    } sample_word_t;

    // Samples still owed by the block, oldest first
    sample_word_t due_samples[$];

    logic [bsrf_pkg::PERIOD_W-1:0] period_q8;
    logic [TIME_W-1:0]             next_time;
    logic signed [25:0]            smooth_q;
    logic signed [25:0]            outpole_q;
    int                            mismatches;

    function automatic longint clamp_pole(input longint v);
        if (v > POLE_HI)
            return POLE_HI;
        if (v < POLE_LO)
            return POLE_LO;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Run the resampler over one input word and queue the samples it owes
    task automatic predict_samples(input logic [31:0] ticks, input logic spk,
                                   input logic [7:0] dac);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] step;
        logic [15:0]       mix;
        longint            dq;
        longint            sm;
        longint            op;
        longint            q;
        int                n;
        sample_word_t      w;
        step = TIME_W'((64'(period_q8) << FRACTION_BITS) >> bsrf_pkg::PERIOD_FRAC);
        now  = TIME_W'(ticks) << FRACTION_BITS;
        mix  = (spk ? 16'h7fff : 16'h0000) + {4'h0, dac, 4'h0};
        dq   = longint'(signed'(mix)) * 256;
        sm   = smooth_q;
        op   = outpole_q;
        n    = 0;
        diff = now - next_time;
        // Emit while the sample time lags, up to the burst limit
        while (n < MAX_BURST && diff != 0 && !diff[TIME_W-1]) begin
            sm = clamp_pole(sm + ((dq - sm) >>> 2));
            op = clamp_pole(op + (((dq - sm - op) * 26214) >>> 16));
            q  = op / 256;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            w.sample      = q[15:0];
            w.last_of_run = 1'b0;
            due_samples.push_back(w);
            next_time = next_time + step;
            n++;
            diff = now - next_time;
        end
        // Mark the final sample of the run
        if (n > 0) begin
            w = due_samples.pop_back();
            w.last_of_run = 1'b1;
            due_samples.push_back(w);
        end
        smooth_q  = sm[25:0];
        outpole_q = op[25:0];
    endtask

    task automatic check_sample(input logic signed [15:0] s, input logic l);
        sample_word_t w;
        if (due_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %0b", s, l));
        end
        else begin
            w = due_samples.pop_front();
            if (s !== w.sample)
                report_mismatch($sformatf("sample %0d, predicted %0d", s, w.sample));
            if (l !== w.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, predicted %0b", l,
                                          w.last_of_run));
        end
    endtask

    // Track the period, check results, then predict for accepted words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_q8  = bsrf_pkg::PERIOD_RESET;
            next_time  = '0;
            smooth_q   = '0;
            outpole_q  = '0;
            mismatches = 0;
            due_samples.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
                period_q8 = cfg_data;
            if (result.valid && result.ready)
                check_sample(result.sample, result.last_of_run);
            if (item.valid && item.ready)
                predict_samples(item.tick_count, item.speaker_level, item.dac_byte);
            fail_count  <= mismatches;
            outstanding <= due_samples.size();
        end
    end

endmodule

// ----- sim/beeper_sample_resampler_filter_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for beeper_sample_resampler_filter_core: clock, reset, period
// writes and input words; the sample checker judges the results.
// Depends on bsrf_pkg, bsrf_if, the core and bsrf_sample_checker.

module beeper_sample_resampler_filter_core_tb;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 40;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [bsrf_pkg::PERIOD_W-1:0] cfg_data;

    bsrf_in_if  words_in ();
    bsrf_out_if samples_out ();

    int                            fail_count;
    int                            outstanding;
    int                            cycles = 0;
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    logic [31:0]                   tick_now;
    logic [bsrf_pkg::PERIOD_W-1:0] period_now;

    beeper_sample_resampler_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .item      (words_in),
        .result    (samples_out)
    );

    bsrf_sample_checker sample_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .item        (words_in),
        .result      (samples_out),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        samples_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic offer_word(input logic [31:0] t, input logic s, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            words_in.valid <= 1'b0;
            @(posedge clk);
        end
        words_in.valid         <= 1'b1;
        words_in.tick_count    <= t;
        words_in.speaker_level <= s;
        words_in.dac_byte      <= d;
        @(posedge clk);
        while (!words_in.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed sample is in and the block is quiet
    task automatic wait_idle();
        words_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_period(input logic [bsrf_pkg::PERIOD_W-1:0] v);
        cfg_write  <= 1'b1;
        cfg_data   <= v;
        period_now = v;
        @(posedge clk);
        cfg_write  <= 1'b0;
    endtask

    // Mostly steady tick advances; some bursts, backward steps and noise
    task automatic offer_random_word();
        int unsigned span;
        int unsigned pick;
        logic [31:0] t;
        logic [7:0]  d;
        span = (period_now >> 8) + 1;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            tick_now = tick_now + $urandom_range(3 * span);
            t = tick_now;
        end
        else if (pick < 80)
        begin
            tick_now = tick_now + $urandom_range(90 * span, 40 * span);
            t = tick_now;
        end
        else if (pick < 88)
            t = tick_now - $urandom_range(4 * span, 1);
        else
            t = $urandom();
        pick = $urandom_range(9);
        if (pick == 0)
            d = 8'd0;
        else if (pick == 1)
            d = 8'hff;
        else
            d = 8'($urandom_range(255));
        offer_word(t, 1'($urandom_range(1)), d);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_write              <= 1'b0;
        cfg_data               <= '0;
        words_in.valid         <= 1'b0;
        words_in.tick_count    <= '0;
        words_in.speaker_level <= 1'b0;
        words_in.dac_byte      <= '0;
        period_now             = bsrf_pkg::PERIOD_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset period
        send_idle_pct = 28;
        recv_idle_pct = 86;
        offer_word(32'd0, 1'b0, 8'd0);          // no lag at tick zero
        offer_word(32'd1, 1'b1, 8'd0);          // full speaker level
        offer_word(32'd300, 1'b0, 8'hff);
        offer_word(32'd2000, 1'b1, 8'hff);      // mix wraps negative
        offer_word(32'd2000, 1'b1, 8'hff);      // caught up
        offer_word(32'd1000, 1'b0, 8'd0);       // tick behind sample time
        offer_word(32'd42000, 1'b0, 8'd128);    // burst limit
        offer_word(32'd42000, 1'b1, 8'd0);      // work off the lag
        offer_word(32'd42000, 1'b0, 8'hff);
        offer_word(32'd42000 + 32'h8000_0000, 1'b1, 8'hff);  // half-range lag reads as lead
        offer_word(32'd42005 + 32'h8000_0000, 1'b1, 8'd1);
        offer_word(32'hffff_ffff, 1'b1, 8'd15);

        // Period of one tick per sample
        wait_idle();
        set_period(24'd256);
        offer_word(32'd42003, 1'b0, 8'd16);
        offer_word(32'd42004, 1'b1, 8'hff);

        // Zero period: full burst on every word, time stands still
        wait_idle();
        set_period(24'd0);
        offer_word(32'd42005, 1'b1, 8'd0);
        offer_word(32'd42005, 1'b0, 8'd200);

        // Largest period
        wait_idle();
        set_period(24'hff_ffff);
        offer_word(32'd173077, 1'b1, 8'd85);
        offer_word(32'd369685, 1'b0, 8'd170);
        tick_now = 32'd369685;

        // Random words over several periods and idle patterns
        for (int seg = 0; seg < 6; seg++)
        begin
            wait_idle();
            case (seg)
                0: set_period(bsrf_pkg::PERIOD_RESET);
                1: set_period(24'd256);
                2: set_period(24'hff_ffff);
                3: set_period(bsrf_pkg::PERIOD_W'($urandom_range(200000, 256)));
                4: set_period(bsrf_pkg::PERIOD_W'($urandom_range(24'hff_ffff, 256)));
                default: set_period(bsrf_pkg::PERIOD_W'($urandom_range(4096, 256)));
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 86;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (27) offer_random_word();
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bsrf_pkg.sv
hw/rtl/bsrf_if.sv
hw/rtl/bsrf_alu.sv
hw/rtl/beeper_sample_resampler_filter_core.sv
sim/bsrf_sample_checker.sv
sim/beeper_sample_resampler_filter_core_tb.sv
